>>> sv/gcoc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcoc_pkg
// Shared types, sizes and codes of the grid cell occupancy counter.
// ----------------------------------------------------------------------------
package gcoc_pkg;

	localparam int unsigned CELLS_X = 16;
	localparam int unsigned CELLS_Y = 16;
	localparam int unsigned CELLS_Z = 16;

	localparam int unsigned COORD_W     = 32;
	localparam int unsigned RECIP_W     = 32;
	localparam int unsigned WEIGHT_W    = 16;
	localparam int unsigned CELL_W      = 32;
	localparam int unsigned TOTAL_W     = 48;
	localparam int unsigned ADDR_W      = 12;
	localparam int unsigned STORE_DEPTH = 4096;
	localparam int unsigned AXIS_W      = 8;
	localparam int unsigned LIN_W       = 3 * AXIS_W;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned NUM_AXES    = 3;

	localparam logic [RECIP_W-1:0] INV_CELL_RESET = 32'd1310720;
	localparam logic [CELL_W-1:0]  CELL_MAX       = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX      = '1;

	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Y   = 3'd1,
		REG_ORIGIN_Z   = 3'd2,
		REG_INV_CELL_X = 3'd3,
		REG_INV_CELL_Y = 3'd4,
		REG_INV_CELL_Z = 3'd5
	} cfg_reg_t;

	typedef logic [NUM_AXES-1:0][COORD_W-1:0] coord3_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][COORD_W-1:0] origin;
		logic [NUM_AXES-1:0][RECIP_W-1:0] inv_cell;
	} geom_t;

	typedef struct packed {
		logic              in_grid;
		logic [ADDR_W-1:0] lin;
	} idx_res_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [CELL_W-1:0] wr_data;
	} mem_req_t;

	function automatic logic [COORD_W-1:0] axis_cells(input logic [1:0] axis);
		logic [COORD_W-1:0] c;
		case (axis)
			2'd0:    c = COORD_W'(CELLS_X);
			2'd1:    c = COORD_W'(CELLS_Y);
			default: c = COORD_W'(CELLS_Z);
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

>>> sv/gcoc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcoc channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface gcoc_in_if import gcoc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [COORD_W-1:0]  pos_x;
	logic [COORD_W-1:0]  pos_y;
	logic [COORD_W-1:0]  pos_z;
	logic [WEIGHT_W-1:0] weight;
	logic [ADDR_W-1:0]   read_cell;

	modport source (output valid, kind, pos_x, pos_y, pos_z, weight, read_cell,
		input ready);
	modport sink (input valid, kind, pos_x, pos_y, pos_z, weight, read_cell,
		output ready);
	modport monitor (input valid, ready, kind, pos_x, pos_y, pos_z, weight, read_cell);
endinterface

interface gcoc_out_if import gcoc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                in_grid;
	logic [ADDR_W-1:0]   cell_index;
	logic [WEIGHT_W-1:0] added;
	logic [CELL_W-1:0]   cell_value;
	logic [TOTAL_W-1:0]  total_weight;

	modport source (output valid, in_grid, cell_index, added, cell_value, total_weight,
		input ready);
	modport sink (input valid, in_grid, cell_index, added, cell_value, total_weight,
		output ready);
	modport monitor (input valid, ready, in_grid, cell_index, added, cell_value,
		total_weight);
endinterface

interface gcoc_cfg_if import gcoc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COORD_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/gcoc_index.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcoc_index
// Cell index unit: one shared 32x32 multiplier steps through the three axes,
// then forms the linear cell address; an axis out of range ends the walk early.
// ----------------------------------------------------------------------------
module gcoc_index import gcoc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire coord3_t  pos,
	input  wire geom_t    geom,
	output logic          done,
	output idx_res_t      res
);

	typedef enum logic [2:0] {IX_IDLE, IX_MUL, IX_CHK, IX_LIN, IX_DONE} ix_state_t;

	ix_state_t                      state_q;
	logic [1:0]                     axis_q;
	logic                           neg_q;
	logic [2*COORD_W-1:0]           prod_q;
	logic [NUM_AXES-1:0][AXIS_W-1:0] idx_q;
	idx_res_t                       res_q;

	logic [COORD_W:0]   u;
	logic [COORD_W-1:0] hi;
	logic               miss;
	logic [LIN_W-1:0]   lin;

	always_comb begin
		u    = {pos[axis_q][COORD_W-1], pos[axis_q]}
			- {geom.origin[axis_q][COORD_W-1], geom.origin[axis_q]};
		hi   = prod_q[2*COORD_W-1:COORD_W];
		miss = neg_q || (hi >= axis_cells(axis_q));
		lin  = (LIN_W'(idx_q[0]) * LIN_W'(CELLS_Y) + LIN_W'(idx_q[1])) * LIN_W'(CELLS_Z)
			+ LIN_W'(idx_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IX_IDLE;
			axis_q  <= '0;
		end else begin
			case (state_q)
				IX_IDLE: begin
					if (start) begin
						axis_q  <= '0;
						state_q <= IX_MUL;
					end
				end
				IX_MUL: state_q <= IX_CHK;
				IX_CHK: begin
					if (miss) begin
						state_q <= IX_DONE;
					end else if (axis_q == 2'(NUM_AXES - 1)) begin
						state_q <= IX_LIN;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= IX_MUL;
					end
				end
				IX_LIN:  state_q <= IX_DONE;
				IX_DONE: state_q <= IX_IDLE;
				default: state_q <= IX_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IX_MUL) begin
			neg_q  <= u[COORD_W];
			prod_q <= u[COORD_W-1:0] * geom.inv_cell[axis_q];
		end
		if (state_q == IX_CHK) begin
			idx_q[axis_q] <= hi[AXIS_W-1:0];
			if (miss) begin
				res_q <= '0;
			end
		end
		if (state_q == IX_LIN) begin
			res_q.in_grid <= (lin < LIN_W'(STORE_DEPTH));
			res_q.lin     <= lin[ADDR_W-1:0];
		end
	end

	assign done = (state_q == IX_DONE);
	assign res  = res_q;

endmodule
`default_nettype wire

>>> sv/gcoc_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcoc_store
// Cell memory with registered read data and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module gcoc_store import gcoc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire mem_req_t  req,
	output logic [CELL_W-1:0] rdata,
	output logic           busy
);

	logic [CELL_W-1:0] mem [STORE_DEPTH];
	logic [ADDR_W-1:0] clr_q;
	logic              clearing_q;
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + ADDR_W'(1);
			if (clr_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= '0;
		end else if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clearing_q;

endmodule
`default_nettype wire

>>> sv/grid_cell_occupancy_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_cell_occupancy_counter
// Three-dimensional occupancy histogram over a 4096-cell store.
// ----------------------------------------------------------------------------
// One request is worked at a time. A count request first goes to the shared
// index multiplier, a multiply and a range check per axis. Then the linear
// address is formed and the index is handed to the controller. Then come a
// memory read and a read-modify-write cycle. A count that falls outside the
// grid gives its result once the index unit reports its failing range check.
// A read request gives its result after a memory read. The next request is
// accepted the cycle after a result is registered, also while that result
// waits at the output. A request that is ready to report while the earlier
// result still waits holds in its final cycle. After reset the block zeroes
// all 4096 cells of the store and takes no request meanwhile. Register writes
// are taken at any time, but they are meant to come only while no request is
// in progress.
// ----------------------------------------------------------------------------
module grid_cell_occupancy_counter import gcoc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	gcoc_in_if.sink   items,
	gcoc_out_if.source results,
	gcoc_cfg_if.sink  cfg
);

	typedef enum logic [2:0] {ST_IDLE, ST_IDX, ST_RDREQ, ST_UPD, ST_MISS} state_t;

	state_t              state_q;
	geom_t               geom_q;
	logic                kind_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [ADDR_W-1:0]   addr_q;
	coord3_t             pos_q;
	logic [TOTAL_W-1:0]  total_q;

	logic                out_valid_q;
	logic                out_in_grid_q;
	logic [ADDR_W-1:0]   out_index_q;
	logic [WEIGHT_W-1:0] out_added_q;
	logic [CELL_W-1:0]   out_value_q;
	logic [TOTAL_W-1:0]  out_total_q;

	logic                accept;
	logic                slot_free;
	logic                out_load;
	logic                idx_done;
	idx_res_t            idx_res;
	mem_req_t            mem_req;
	logic [CELL_W-1:0]   rdata;
	logic                busy;
	logic [CELL_W-1:0]   room32;
	logic [WEIGHT_W-1:0] add;
	logic [CELL_W-1:0]   new_val;
	logic [TOTAL_W-1:0]  room48;
	logic [TOTAL_W-1:0]  tot_inc;

	assign items.ready = (state_q == ST_IDLE) && !busy;
	assign accept      = items.valid && items.ready;
	assign slot_free   = !out_valid_q || results.ready;
	assign out_load    = ((state_q == ST_UPD) || (state_q == ST_MISS)) && slot_free;
	assign cfg.ready   = 1'b1;

	gcoc_index u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (items.kind == KIND_COUNT)),
		.pos    (pos_q),
		.geom   (geom_q),
		.done   (idx_done),
		.res    (idx_res)
	);

	gcoc_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (rdata),
		.busy   (busy)
	);

	always_comb begin
		room32  = CELL_MAX - rdata;
		add     = ({{(CELL_W-WEIGHT_W){1'b0}}, weight_q} < room32) ? weight_q
			: room32[WEIGHT_W-1:0];
		new_val = rdata + CELL_W'(add);
		room48  = TOTAL_MAX - total_q;
		tot_inc = (TOTAL_W'(add) < room48) ? TOTAL_W'(add) : room48;

		mem_req         = '0;
		mem_req.rd_en   = (state_q == ST_RDREQ);
		mem_req.rd_addr = addr_q;
		mem_req.wr_en   = (state_q == ST_UPD) && slot_free && (kind_q == KIND_COUNT);
		mem_req.wr_addr = addr_q;
		mem_req.wr_data = new_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.origin   <= '0;
			geom_q.inv_cell <= {NUM_AXES{INV_CELL_RESET}};
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_ORIGIN_X:   geom_q.origin[0]   <= cfg.data;
				REG_ORIGIN_Y:   geom_q.origin[1]   <= cfg.data;
				REG_ORIGIN_Z:   geom_q.origin[2]   <= cfg.data;
				REG_INV_CELL_X: geom_q.inv_cell[0] <= cfg.data;
				REG_INV_CELL_Y: geom_q.inv_cell[1] <= cfg.data;
				REG_INV_CELL_Z: geom_q.inv_cell[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= items.kind;
			weight_q <= items.weight;
			pos_q    <= {items.pos_z, items.pos_y, items.pos_x};
		end
		if (accept && (items.kind == KIND_READ)) begin
			addr_q <= items.read_cell;
		end else if ((state_q == ST_IDX) && idx_done) begin
			addr_q <= idx_res.lin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			total_q       <= '0;
			out_valid_q   <= 1'b0;
			out_in_grid_q <= 1'b0;
			out_index_q   <= '0;
			out_added_q   <= '0;
			out_value_q   <= '0;
			out_total_q   <= '0;
		end else begin
			if (out_valid_q && results.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (items.kind == KIND_READ) ? ST_RDREQ : ST_IDX;
					end
				end
				ST_IDX: begin
					if (idx_done) begin
						state_q <= idx_res.in_grid ? ST_RDREQ : ST_MISS;
					end
				end
				ST_RDREQ: state_q <= ST_UPD;
				ST_UPD: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_index_q <= addr_q;
						if (kind_q == KIND_COUNT) begin
							out_in_grid_q <= 1'b1;
							out_added_q   <= add;
							out_value_q   <= new_val;
							out_total_q   <= total_q + tot_inc;
							total_q       <= total_q + tot_inc;
						end else begin
							out_in_grid_q <= 1'b0;
							out_added_q   <= '0;
							out_value_q   <= rdata;
							out_total_q   <= total_q;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_MISS: begin
					if (slot_free) begin
						out_valid_q   <= 1'b1;
						out_in_grid_q <= 1'b0;
						out_index_q   <= '0;
						out_added_q   <= '0;
						out_value_q   <= '0;
						out_total_q   <= total_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid        = out_valid_q;
	assign results.in_grid      = out_in_grid_q;
	assign results.cell_index   = out_index_q;
	assign results.added        = out_added_q;
	assign results.cell_value   = out_value_q;
	assign results.total_weight = out_total_q;

endmodule
`default_nettype wire

>>> sv/gcoc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcoc_checker
// Port-level checks of the occupancy counter, bound to the top level.
// ----------------------------------------------------------------------------
module gcoc_checker import gcoc_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                valid,
	input wire logic                ready,
	input wire logic                in_grid,
	input wire logic [WEIGHT_W-1:0] added,
	input wire logic [CELL_W-1:0]   cell_value,
	input wire logic [TOTAL_W-1:0]  total_weight
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result valid dropped while stalled");

	a_hold_value: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(cell_value) && $stable(total_weight))
		else $error("result payload changed while stalled");

	a_miss_adds_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !in_grid |-> added == '0)
		else $error("weight added outside the grid");

	a_hit_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		valid && in_grid |->
		(cell_value >= CELL_W'(added)) && (total_weight >= TOTAL_W'(added)))
		else $error("cell or total below the weight just added");

endmodule

bind grid_cell_occupancy_counter gcoc_checker u_gcoc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (results.valid),
	.ready        (results.ready),
	.in_grid      (results.in_grid),
	.added        (results.added),
	.cell_value   (results.cell_value),
	.total_weight (results.total_weight)
);
`default_nettype wire

>>> dv/grid_cell_occupancy_counter_tb.sv
// ----------------------------------------------------------------------------
// grid_cell_occupancy_counter_tb
// Drives count and read requests into the occupancy histogram with random
// gaps on both channels. A local model of the grid mapping, the cell store
// and the running weight total predicts every result, which is checked field
// by field in order. It covers the grid corners and edges, extreme origins and
// reciprocals, a zero reciprocal, one cell hit back to back at full weight and
// random geometries.
// ----------------------------------------------------------------------------
module grid_cell_occupancy_counter_tb;
	import gcoc_pkg::*;

	localparam int unsigned STALL_LIMIT  = 20000;
	localparam int unsigned DRAIN_CYCLES = 30;
	localparam int unsigned REPORT_MAX   = 10;
	localparam int unsigned RANDOM_ITEMS = 810;
	localparam int unsigned PHASES       = 6;

	typedef struct packed {
		logic                kind;
		coord3_t             pos;
		logic [WEIGHT_W-1:0] weight;
		logic [ADDR_W-1:0]   read_cell;
	} hist_request_t;

	typedef struct packed {
		logic                in_grid;
		logic [ADDR_W-1:0]   cell_index;
		logic [WEIGHT_W-1:0] added;
		logic [CELL_W-1:0]   cell_value;
		logic [TOTAL_W-1:0]  total_weight;
	} hist_result_t;

	logic clk;
	logic arst_n;

	gcoc_in_if  in_ch ();
	gcoc_out_if res_ch ();
	gcoc_cfg_if cfg_ch ();

	grid_cell_occupancy_counter u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (in_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	logic [COORD_W-1:0] grid_origin [NUM_AXES];
	logic [RECIP_W-1:0] cell_recip [NUM_AXES];
	logic [CELL_W-1:0]  cell_count [STORE_DEPTH];
	logic [TOTAL_W-1:0] weight_sum;

	hist_result_t      expected_q[$];
	logic [ADDR_W-1:0] touched_cells[$];

	bit          steady;
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned stalled;
	int unsigned n_hits;
	int unsigned n_misses;
	int unsigned n_reads;
	int unsigned n_settings;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned idle_draw();
		return steady ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic logic locate_axis(input logic [COORD_W-1:0] pos, input int axis,
		input int unsigned cells, output int unsigned idx);
		longint      offset;
		logic [63:0] prod;
		idx = 0;
		offset = longint'($signed(pos)) - longint'($signed(grid_origin[axis]));
		if (offset < 0)
			return 1'b0;
		prod = {32'b0, offset[31:0]} * {32'b0, cell_recip[axis]};
		if (prod[63:32] >= cells)
			return 1'b0;
		idx = prod[63:32];
		return 1'b1;
	endfunction

	function automatic hist_result_t predict_histogram(input hist_request_t req);
		hist_result_t       r;
		int unsigned        ix, iy, iz, lin;
		logic [CELL_W-1:0]  room, gain;
		logic [TOTAL_W-1:0] total_room;
		r = '0;
		r.total_weight = weight_sum;
		if (req.kind == KIND_READ) begin
			r.cell_index = req.read_cell;
			r.cell_value = cell_count[req.read_cell];
			return r;
		end
		if (!locate_axis(req.pos[0], 0, CELLS_X, ix) ||
			!locate_axis(req.pos[1], 1, CELLS_Y, iy) ||
			!locate_axis(req.pos[2], 2, CELLS_Z, iz))
			return r;
		lin = (ix * CELLS_Y + iy) * CELLS_Z + iz;
		if (lin >= STORE_DEPTH)
			return r;
		room = CELL_MAX - cell_count[lin];
		gain = (CELL_W'(req.weight) < room) ? CELL_W'(req.weight) : room;
		cell_count[lin] = cell_count[lin] + gain;
		total_room = TOTAL_MAX - weight_sum;
		weight_sum = weight_sum + ((TOTAL_W'(gain) < total_room) ? TOTAL_W'(gain) : total_room);
		r.in_grid      = 1'b1;
		r.cell_index   = lin[ADDR_W-1:0];
		r.added        = gain[WEIGHT_W-1:0];
		r.cell_value   = cell_count[lin];
		r.total_weight = weight_sum;
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(input int axis, input int unsigned cells);
		longint span, offset;
		if (cell_recip[axis] == '0)
			span = 64'h1_0000_0000;
		else begin
			span = ((longint'(cells) << 32) + longint'(cell_recip[axis]) - 1) /
				longint'(cell_recip[axis]);
			if (span > 64'h1_0000_0000)
				span = 64'h1_0000_0000;
		end
		case ($urandom_range(0, 19))
			0:       return $urandom;
			1:       offset = -1;
			2:       offset = 0;
			3:       offset = span - 1;
			4:       offset = span;
			5:       offset = -longint'($urandom_range(1, 1 << 16));
			default: offset = longint'($urandom) % (span + span / 8 + 1);
		endcase
		return grid_origin[axis] + offset[COORD_W-1:0];
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	task automatic send_request(input hist_request_t req);
		int unsigned  n;
		hist_result_t r;
		n = idle_draw();
		@(negedge clk);
		if (n != 0) begin
			in_ch.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.kind      <= req.kind;
		in_ch.pos_x     <= req.pos[0];
		in_ch.pos_y     <= req.pos[1];
		in_ch.pos_z     <= req.pos[2];
		in_ch.weight    <= req.weight;
		in_ch.read_cell <= req.read_cell;
		do @(posedge clk); while (!in_ch.ready);
		r = predict_histogram(req);
		expected_q.push_back(r);
		if (req.kind == KIND_READ)
			n_reads++;
		else if (r.in_grid) begin
			n_hits++;
			touched_cells.push_back(r.cell_index);
			if (touched_cells.size() > 64)
				void'(touched_cells.pop_front());
		end else
			n_misses++;
	endtask

	task automatic send_count(input logic [COORD_W-1:0] x, y, z, input logic [WEIGHT_W-1:0] w);
		hist_request_t req;
		req.kind      = KIND_COUNT;
		req.pos       = {z, y, x};
		req.weight    = w;
		req.read_cell = ADDR_W'($urandom);
		send_request(req);
	endtask

	task automatic send_read(input logic [ADDR_W-1:0] addr);
		hist_request_t req;
		req.kind      = KIND_READ;
		req.pos       = {$urandom, $urandom, $urandom};
		req.weight    = WEIGHT_W'($urandom);
		req.read_cell = addr;
		send_request(req);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_register(input cfg_reg_t idx, input logic [COORD_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx <= REG_ORIGIN_Z)
			grid_origin[idx] = value;
		else
			cell_recip[idx - REG_INV_CELL_X] = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic apply_geometry(input coord3_t org, input coord3_t inv);
		for (int a = 0; a < NUM_AXES; a++) begin
			set_register(cfg_reg_t'(REG_ORIGIN_X + a), org[a]);
			set_register(cfg_reg_t'(REG_INV_CELL_X + a), inv[a]);
		end
		n_settings++;
	endtask

	task automatic test_default_grid();
		send_count(32'd0, 32'd0, 32'd0, 16'h0100);
		send_count(32'd52428, 32'd52428, 32'd52428, 16'hFFFF);
		send_count(32'd52429, 32'd0, 32'd0, 16'h0001);
		send_count(32'd0, 32'hFFFF_FFFF, 32'd0, 16'h0001);
		send_count(32'd0, 32'd0, 32'd52429, 16'h0001);
		send_count(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
		send_count(32'd3277, 32'd6554, 32'd9831, 16'h0000);
		send_read(12'd0);
		send_read(12'hFFF);
		send_read(12'd291);
		send_read(12'd1);
	endtask

	task automatic test_extreme_settings();
		apply_geometry({3{32'h8000_0000}}, {3{32'd1}});
		send_count(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 16'hFFFF);
		send_count(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hA5A5);
		apply_geometry({3{32'h7FFF_FFFF}}, {3{32'hFFFF_FFFF}});
		send_count(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h5A5A);
		send_count(32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0001);
		send_read(12'd0);
	endtask

	task automatic test_zero_recip();
		apply_geometry('0, '0);
		send_count(32'h7FFF_FFFF, 32'd0, 32'd12345, 16'h1234);
		send_count(32'hFFFF_FFFF, 32'd0, 32'd0, 16'h1234);
	endtask

	task automatic test_heavy_cell();
		apply_geometry('0, {3{INV_CELL_RESET}});
		steady = 1'b1;
		repeat (16)
			send_count(32'd52428, 32'd52428, 32'd52428, 16'hFFFF);
		steady = 1'b0;
		send_read(12'hFFF);
	endtask

	task automatic test_random_traffic();
		coord3_t       org, inv;
		hist_request_t req;
		bit            steady_phase;
		for (int p = 0; p < PHASES; p++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				case ($urandom_range(0, 3))
					0:       org[a] = '0;
					1:       org[a] = $urandom;
					2:       org[a] = COORD_W'($urandom_range(0, 1 << 21)) - (1 << 20);
					default: org[a] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				endcase
				case ($urandom_range(0, 7))
					0:       inv[a] = '0;
					1:       inv[a] = '1;
					2:       inv[a] = INV_CELL_RESET;
					default: inv[a] = $urandom_range(1 << 12, 1 << 24);
				endcase
			end
			if (p == 0) begin
				org = '0;
				inv = {3{INV_CELL_RESET}};
			end
			apply_geometry(org, inv);
			steady_phase = (p == PHASES - 1);
			steady = steady_phase;
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
				if (!steady_phase && $urandom_range(0, 29) == 0)
					steady = !steady;
				if ($urandom_range(0, 3) == 0) begin
					if (touched_cells.size() != 0 && $urandom_range(0, 1))
						send_read(touched_cells[$urandom_range(0, touched_cells.size() - 1)]);
					else
						send_read(ADDR_W'($urandom));
				end else begin
					req.kind      = KIND_COUNT;
					req.pos[0]    = pick_coord(0, CELLS_X);
					req.pos[1]    = pick_coord(1, CELLS_Y);
					req.pos[2]    = pick_coord(2, CELLS_Z);
					req.weight    = pick_weight();
					req.read_cell = ADDR_W'($urandom);
					send_request(req);
				end
			end
			steady = 1'b0;
		end
	endtask

	initial begin : drain_results
		int unsigned n;
		forever begin
			n = idle_draw();
			if (n != 0) begin
				@(negedge clk);
				res_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
				res_ch.ready <= 1'b1;
			end
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	always @(posedge clk) begin : check_results
		hist_result_t got, want;
		if (res_ch.valid && res_ch.ready) begin
			results_seen++;
			got = {res_ch.in_grid, res_ch.cell_index, res_ch.added, res_ch.cell_value,
				res_ch.total_weight};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result %0d arrived with nothing pending: in_grid %0d cell %0d added %0d value %0d total %0d",
						results_seen, got.in_grid, got.cell_index, got.added, got.cell_value,
						got.total_weight);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("result %0d expected: in_grid %0d cell %0d added %0d value %0d total %0d",
							results_seen, want.in_grid, want.cell_index, want.added,
							want.cell_value, want.total_weight);
						$display("result %0d actual:   in_grid %0d cell %0d added %0d value %0d total %0d",
							results_seen, got.in_grid, got.cell_index, got.added,
							got.cell_value, got.total_weight);
					end
				end
			end
		end
	end

	initial begin : watchdog
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("no request or result moved for %0d cycles", STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		in_ch.valid     = 1'b0;
		in_ch.kind      = KIND_COUNT;
		in_ch.pos_x     = '0;
		in_ch.pos_y     = '0;
		in_ch.pos_z     = '0;
		in_ch.weight    = '0;
		in_ch.read_cell = '0;
		res_ch.ready    = 1'b1;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = REG_ORIGIN_X;
		cfg_ch.data     = '0;
		arst_n          = 1'b0;
		steady          = 1'b0;
		mismatches      = 0;
		results_seen    = 0;
		n_hits          = 0;
		n_misses        = 0;
		n_reads         = 0;
		n_settings      = 1;
		weight_sum      = '0;
		for (int a = 0; a < NUM_AXES; a++) begin
			grid_origin[a] = '0;
			cell_recip[a]  = INV_CELL_RESET;
		end
		for (int c = 0; c < STORE_DEPTH; c++)
			cell_count[c] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_grid();
		test_extreme_settings();
		test_zero_recip();
		test_heavy_cell();
		test_random_traffic();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d results: %0d counts in the grid, %0d outside it, %0d cell reads.",
			results_seen, n_hits, n_misses, n_reads);
		$display("Geometries applied: %0d, one cell hit back to back; mismatches: %0d.",
			n_settings, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
